// ===== src/b24r_pkg.sv =====
// ----------------------------------------------------------------------------
// b24r_pkg
// Shared types and constants of the 24-bit BMP to RGB565 stream decoder.
// ----------------------------------------------------------------------------
package b24r_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 3;
  localparam int DIM_W   = 11;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int STAT_W  = 6;
  localparam int OUT_D_W = 56;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_FORCE_TRANSP  = 3'd4;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 11'd480;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 11'd320;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // status bits
  localparam int ST_DEPTH  = 0;
  localparam int ST_COMPR  = 1;
  localparam int ST_PLANES = 2;
  localparam int ST_SIG    = 3;
  localparam int ST_ORIGIN = 4;
  localparam int ST_SIZE   = 5;

  // header byte positions at which a field is complete
  localparam logic [31:0] POS_SIG    = 32'd1;
  localparam logic [31:0] POS_OFFSET = 32'd13;
  localparam logic [31:0] POS_HLEN   = 32'd17;
  localparam logic [31:0] POS_WIDTH  = 32'd21;
  localparam logic [31:0] POS_HEIGHT = 32'd25;
  localparam logic [31:0] POS_PLANES = 32'd27;
  localparam logic [31:0] POS_DEPTH  = 32'd29;
  localparam logic [31:0] POS_COMPR  = 32'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH_24  = 16'd24;
  localparam logic [15:0] BMP_PLANES_1  = 16'd1;
  localparam logic [31:0] BMP_SHORT_HDR = 32'd12;

  typedef struct packed {
    logic [DIM_W-1:0]          screen_width;
    logic [DIM_W-1:0]          screen_height;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic                      force_transparent;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [STAT_W-1:0]  status;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
    logic               write_enable;
    logic               last;
  } result_t;

endpackage

// ===== src/bmp24_stream_to_rgb565_top.sv =====
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565_top
// Streams a 24-bit BMP file in byte by byte and streams out a header verdict
// followed by RGB565 pixels with screen coordinates.
// ----------------------------------------------------------------------------
// Input channel: one file byte per word in in_tdata; in_tuser high marks byte
// zero of a new file and restarts the parser.
// Output channel: out_tuser gives the kind (verdict or pixel), out_tlast marks
// the final pixel or a failing or empty verdict.
// Configuration: write screen size, image center and forced keying through
// cfg_we/cfg_addr/cfg_wdata while no file is in flight.
// Throughput: one byte per cycle while in_tready is high; the header parse
// and the BGR to RGB565 conversion fit in the single logic stage in front of
// the result register. A result is registered in the output buffer when the
// byte that completes it is accepted.
// Reset: parser returns to header parse, registers return to 480x320, center
// 0,0, no forced keying; the output buffer empties.
// Stall: a two-word output buffer keeps bytes flowing while one result waits;
// in_tready drops only when both words are held.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565_top import b24r_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] file_byte
  input  logic               in_tuser,   // [0] first_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_D_W-1:0] out_tdata,  // [5:0] status, [21:6] pixel_x,
                                         // [37:22] pixel_y, [53:38] color,
                                         // [54] write_enable, [55] zero
  output logic               out_tuser,  // [0] kind
  output logic               out_tlast,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  cfg_t    cfg_r;
  logic    acc;
  logic    res_valid;
  result_t res;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width      <= SCREEN_WIDTH_RST;
      cfg_r.screen_height     <= SCREEN_HEIGHT_RST;
      cfg_r.center_x          <= '0;
      cfg_r.center_y          <= '0;
      cfg_r.force_transparent <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCREEN_WIDTH:  cfg_r.screen_width      <= cfg_wdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height     <= cfg_wdata[DIM_W-1:0];
        REG_CENTER_X:      cfg_r.center_x          <= cfg_wdata;
        REG_CENTER_Y:      cfg_r.center_y          <= cfg_wdata;
        REG_FORCE_TRANSP:  cfg_r.force_transparent <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign acc = in_tvalid && in_tready;

  b24r_core #(
    .MAX_DIM(MAX_DIM)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc       (acc),
    .file_byte (in_tdata),
    .first_byte(in_tuser),
    .res_valid (res_valid),
    .res       (res)
  );

  b24r_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_valid),
    .push_data (res),
    .push_ready(in_tready),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {1'b0, out_res.write_enable, out_res.color, out_res.pixel_y,
                      out_res.pixel_x, out_res.status};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

`ifndef NO_ASSERTIONS
  a_pixel_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PIXEL) |-> (out_tdata[5:0] == '0))
    else $error("pixel word carries status bits");

  a_verdict_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_VERDICT) |-> (out_tdata[OUT_D_W-1:6] == '0))
    else $error("verdict word carries pixel fields");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_VERDICT) && (out_tdata[5:0] != '0) |-> out_tlast)
    else $error("failing verdict without last");

  a_full_means_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");
`endif

endmodule

// ===== src/b24r_core.sv =====
// ----------------------------------------------------------------------------
// b24r_core
// Header parser and pixel converter: one file byte per accepted word.
// ----------------------------------------------------------------------------
module b24r_core import b24r_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                acc,
  input  logic [BYTE_W-1:0]   file_byte,
  input  logic                first_byte,
  output logic                res_valid,
  output result_t             res
);

  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW    = CNT_W + 18;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_WAIT   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [31:0]        pos;
    logic [31:0]        shift;
    logic [31:0]        offset;
    logic [31:0]        hlen;
    logic [31:0]        width;
    logic [31:0]        height;
    logic [STAT_W-1:0]  err;
    logic [1:0]         pad;
    logic [CNT_W-1:0]   col;
    logic [CNT_W-1:0]   row;
    logic [1:0]         bip;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] key;
    logic               key_en;
  } st_t;

  st_t st_r, st_nxt;
  st_t cur, nx;

  logic [31:0]         sh;
  logic [STAT_W-1:0]   hdr_err, vr_err;
  logic                do_verdict, do_pix, empty, good;
  logic [2:0]          bip_inc;
  logic [COLOR_W-1:0]  color, key_now;
  logic                first_px, key_en_now, on_screen;
  logic signed [PW-1:0] px_s, py_s;
  logic                col_end, row_end;

  always_comb begin
    cur        = first_byte ? st_t'('0) : st_r;
    nx         = cur;
    res_valid  = 1'b0;
    res        = '0;
    do_verdict = 1'b0;
    do_pix     = 1'b0;
    hdr_err    = cur.err;
    vr_err     = '0;
    empty      = 1'b0;
    good       = 1'b0;
    sh         = {file_byte, cur.shift[31:8]};
    bip_inc    = 3'(cur.bip) + 3'd1;
    color      = {file_byte[7:3], cur.bg[15:10], cur.bg[7:3]};
    first_px   = (cur.row == '0) && (cur.col == '0);
    key_now    = first_px ? color : cur.key;
    key_en_now = first_px ? ((color == '0) || cfg.force_transparent) : cur.key_en;
    px_s       = PW'(cfg.center_x) - signed'(PW'(cur.width[CNT_W:1]))
                 + signed'(PW'(cur.col));
    py_s       = PW'(cfg.center_y) + signed'(PW'(cur.height[CNT_W:1]))
                 - signed'(PW'(1)) - signed'(PW'(cur.row));
    on_screen  = !px_s[PW-1] && (px_s < signed'(PW'(cfg.screen_width)))
                 && !py_s[PW-1] && (py_s < signed'(PW'(cfg.screen_height)));
    col_end    = (33'(cur.col) + 33'd1) >= {1'b0, cur.width};
    row_end    = (33'(cur.row) + 33'd1) >= {1'b0, cur.height};

    nx.pos = (&cur.pos) ? cur.pos : cur.pos + 32'd1;

    case (cur.phase)
      PH_HEADER: begin
        nx.shift = sh;
        case (cur.pos)
          POS_SIG: begin
            if (sh[31:16] != BMP_SIGNATURE) begin
              nx.err          = '0;
              nx.err[ST_SIG]  = 1'b1;
              nx.phase        = PH_DONE;
              res_valid       = 1'b1;
              res.kind        = KIND_VERDICT;
              res.status      = nx.err;
              res.last        = 1'b1;
            end
          end
          POS_OFFSET: nx.offset = sh;
          POS_HLEN:   nx.hlen   = sh;
          POS_WIDTH:  nx.width  = sh;
          POS_HEIGHT: nx.height = sh;
          POS_PLANES: begin
            if (sh[31:16] != BMP_PLANES_1) hdr_err[ST_PLANES] = 1'b1;
            nx.err = hdr_err;
          end
          POS_DEPTH: begin
            if (sh[31:16] != BMP_DEPTH_24) hdr_err[ST_DEPTH] = 1'b1;
            nx.err     = hdr_err;
            do_verdict = (cur.hlen <= BMP_SHORT_HDR);
          end
          POS_COMPR: begin
            if (sh != '0) hdr_err[ST_COMPR] = 1'b1;
            nx.err     = hdr_err;
            do_verdict = 1'b1;
          end
          default: ;
        endcase
      end
      PH_WAIT: begin
        if (cur.pos >= cur.offset) begin
          nx.phase = PH_PIXEL;
          do_pix   = 1'b1;
        end
      end
      PH_PIXEL: do_pix = 1'b1;
      PH_PAD: begin
        if (bip_inc >= 3'(cur.pad)) begin
          nx.bip   = '0;
          nx.phase = PH_PIXEL;
        end else begin
          nx.bip = bip_inc[1:0];
        end
      end
      default: ;
    endcase

    if (do_verdict) begin
      vr_err = hdr_err;
      if (($signed({cfg.center_x[15], cfg.center_x}) >= $signed({6'd0, cfg.screen_width}))
          || ($signed({cfg.center_y[15], cfg.center_y})
              >= $signed({6'd0, cfg.screen_height}))) begin
        vr_err[ST_ORIGIN] = 1'b1;
      end
      if ((cur.width > 32'(MAX_DIM)) || (cur.height > 32'(MAX_DIM))) begin
        vr_err[ST_SIZE] = 1'b1;
      end
      good       = (vr_err == '0);
      empty      = (cur.width == '0) || (cur.height == '0);
      nx.err     = vr_err;
      nx.pad     = cur.width[1:0];
      nx.col     = '0;
      nx.row     = '0;
      nx.bip     = '0;
      nx.phase   = (good && !empty) ? PH_WAIT : PH_DONE;
      res_valid  = 1'b1;
      res.kind   = KIND_VERDICT;
      res.status = vr_err;
      res.last   = !good || empty;
    end

    if (do_pix) begin
      case (cur.bip)
        2'd0: begin
          nx.bg[7:0] = file_byte;
          nx.bip     = 2'd1;
        end
        2'd1: begin
          nx.bg[15:8] = file_byte;
          nx.bip      = 2'd2;
        end
        default: begin
          nx.bip           = '0;
          nx.key           = key_now;
          nx.key_en        = key_en_now;
          res_valid        = 1'b1;
          res.kind         = KIND_PIXEL;
          res.pixel_x      = px_s[COORD_W-1:0];
          res.pixel_y      = py_s[COORD_W-1:0];
          res.color        = color;
          res.write_enable = on_screen && !(key_en_now && (color == key_now));
          if (col_end) begin
            nx.col = '0;
            if (row_end) begin
              res.last = 1'b1;
              nx.phase = PH_DONE;
            end else begin
              nx.row = cur.row + CNT_W'(1);
              if (cur.pad != '0) nx.phase = PH_PAD;
            end
          end else begin
            nx.col = cur.col + CNT_W'(1);
          end
        end
      endcase
    end

    st_nxt = acc ? nx : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== src/b24r_obuf.sv =====
// ----------------------------------------------------------------------------
// b24r_obuf
// Two-word result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module b24r_obuf import b24r_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    pop;

  assign pop        = out_v_r && out_ready;
  assign push_ready = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      if (out_v_r) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end else begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

// ===== dv/bmp24_stream_to_rgb565_top_test.sv =====
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565_top_test
// Streams BMP files, some well formed, some damaged or cut short, through the
// decoder and checks every verdict and pixel word against a cycle-free model
// of the parser. Screen size, image center and forced keying are changed
// between files, with both stream sides stalling at random.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565_top_test;
  import b24r_pkg::*;

  localparam int MAX_DIM      = 1024;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_BYTES = 450;
  localparam int MAX_REPORTS  = 40;

  localparam logic [STAT_W-1:0] E_NONE   = '0;
  localparam logic [STAT_W-1:0] E_DEPTH  = STAT_W'(1 << ST_DEPTH);
  localparam logic [STAT_W-1:0] E_COMPR  = STAT_W'(1 << ST_COMPR);
  localparam logic [STAT_W-1:0] E_PLANES = STAT_W'(1 << ST_PLANES);
  localparam logic [STAT_W-1:0] E_SIG    = STAT_W'(1 << ST_SIG);
  localparam logic [STAT_W-1:0] E_ORIGIN = STAT_W'(1 << ST_ORIGIN);
  localparam logic [STAT_W-1:0] E_SIZE   = STAT_W'(1 << ST_SIZE);

  typedef enum logic [2:0] {
    PARSE_HDR, SEEK_DATA, TAKE_PIXEL, SKIP_PAD, IMAGE_DONE
  } parse_phase_e;

  typedef struct {
    logic [15:0]       sig;
    logic [31:0]       offset;
    logic [31:0]       hlen;
    logic [31:0]       width;
    logic [31:0]       height;
    logic [15:0]       planes;
    logic [15:0]       depth;
    logic [31:0]       compr;
    logic              mark_first;
    int                cut;
    logic              typed;
    logic [STAT_W-1:0] t_status;
    logic              t_last;
  } bmp_file_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [BYTE_W-1:0]  in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_D_W-1:0] out_tdata;
  logic               out_tuser;
  logic               out_tlast;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  bmp24_stream_to_rgb565_top #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // decoder model state
  cfg_t         m_cfg;
  parse_phase_e phase_q;
  logic [31:0]  hdr_pos, hdr_shift, pix_offset, hdr_len, img_w, img_h;
  logic [5:0]   err_bits;
  logic         img_ok;
  logic [1:0]   pad_len;
  logic [10:0]  col_idx, row_idx;
  logic [1:0]   bgr_idx;
  logic [15:0]  bg_hold, key_rgb;
  logic         key_on;

  result_t           pending_results[$];
  logic [BYTE_W-1:0] file_bytes[$];
  int                mismatch_count = 0;
  int                live_bytes = 0;
  int                idle_pct = 29;
  int                stall_cycles = 0;
  logic              typed_on = 1'b0;
  logic [STAT_W-1:0] typed_status = '0;
  logic              typed_last = 1'b0;

  bmp_file_t dir_files [19] = '{
    '{BMP_SIGNATURE, 54, 40, 2, 2, BMP_PLANES_1, BMP_DEPTH_24, 0, 0, 0, 1, E_NONE, 0},
    '{16'h4D43, 54, 40, 2, 2, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1, E_SIG, 1},
    '{16'h0000, 0, 0, 0, 0, 16'h0000, 16'h0000, 0, 1, 0, 1, E_SIG, 1},
    '{16'hFFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
      'hFFFF_FFFF, 1, 0, 1, E_SIG, 1},
    '{BMP_SIGNATURE, 54, 40, 2, 2, BMP_PLANES_1, 16'd16, 0, 1, 0, 1, E_DEPTH, 1},
    '{BMP_SIGNATURE, 54, 40, 2, 2, BMP_PLANES_1, BMP_DEPTH_24, 'hFFFF_FFFF, 1, 0, 1,
      E_COMPR, 1},
    '{BMP_SIGNATURE, 54, 40, 2, 2, 16'd0, BMP_DEPTH_24, 0, 1, 0, 1, E_PLANES, 1},
    '{BMP_SIGNATURE, 54, 40, 1025, 2, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1, E_SIZE, 1},
    '{BMP_SIGNATURE, 54, 40, 2, 'hFFFF_FFFF, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1,
      E_SIZE, 1},
    '{BMP_SIGNATURE, 54, 40, 4000, 2, 16'd2, 16'd8, 1, 1, 0, 1,
      E_PLANES | E_DEPTH | E_COMPR | E_SIZE, 1},
    '{BMP_SIGNATURE, 54, 40, 0, 3, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1, E_NONE, 1},
    '{BMP_SIGNATURE, 54, 40, 3, 0, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1, E_NONE, 1},
    '{BMP_SIGNATURE, 34, 12, 3, 2, BMP_PLANES_1, BMP_DEPTH_24, 7, 1, 0, 1, E_NONE, 0},
    '{BMP_SIGNATURE, 40, 13, 1, 3, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 0, E_NONE, 0},
    '{BMP_SIGNATURE, 5, 40, 2, 2, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 0, E_NONE, 0},
    '{BMP_SIGNATURE, 54, 40, 1024, 1, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1, E_NONE, 0},
    '{BMP_SIGNATURE, 54, 40, 1, 1024, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 1, E_NONE, 0},
    '{BMP_SIGNATURE, 54, 40, 4, 3, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 45, 0, E_NONE, 0},
    '{BMP_SIGNATURE, 54, 40, 3, 2, BMP_PLANES_1, BMP_DEPTH_24, 0, 1, 0, 0, E_NONE, 0}
  };

  function automatic void restart_decoder();
    phase_q = PARSE_HDR;
    hdr_pos = '0; hdr_shift = '0; pix_offset = '0; hdr_len = '0;
    img_w = '0; img_h = '0; err_bits = '0; img_ok = 1'b0; pad_len = '0;
    col_idx = '0; row_idx = '0; bgr_idx = '0; bg_hold = '0;
    key_rgb = '0; key_on = 1'b0;
  endfunction

  function automatic void close_header(output result_t r);
    logic [31:0] w3;
    if (int'(m_cfg.center_x) >= int'(m_cfg.screen_width) ||
        int'(m_cfg.center_y) >= int'(m_cfg.screen_height))
      err_bits |= E_ORIGIN;
    if (img_w > MAX_DIM || img_h > MAX_DIM)
      err_bits |= E_SIZE;
    img_ok = (err_bits == 0);
    w3 = img_w * 3;
    pad_len = 2'd0 - w3[1:0];
    col_idx = '0;
    row_idx = '0;
    bgr_idx = '0;
    r = '0;
    r.kind = KIND_VERDICT;
    r.status = err_bits;
    r.last = !img_ok || img_w == 0 || img_h == 0;
    phase_q = r.last ? IMAGE_DONE : SEEK_DATA;
  endfunction

  function automatic logic take_pixel(input logic [7:0] b, output result_t r);
    logic [15:0] rgb;
    int          px, py;
    logic        draw, last_px;
    r = '0;
    if (bgr_idx == 2'd0) begin
      bg_hold = {8'h00, b};
      bgr_idx = 2'd1;
      return 1'b0;
    end
    if (bgr_idx == 2'd1) begin
      bg_hold[15:8] = b;
      bgr_idx = 2'd2;
      return 1'b0;
    end
    bgr_idx = 2'd0;
    rgb = {b[7:3], bg_hold[15:10], bg_hold[7:3]};
    if (row_idx == 0 && col_idx == 0) begin
      key_rgb = rgb;
      key_on = (rgb == 0) || m_cfg.force_transparent;
    end
    px = int'(m_cfg.center_x) - int'(img_w >> 1) + int'(col_idx);
    py = int'(m_cfg.center_y) + int'(img_h >> 1) - 1 - int'(row_idx);
    draw = px >= 0 && px < int'(m_cfg.screen_width) &&
           py >= 0 && py < int'(m_cfg.screen_height);
    if (key_on && rgb == key_rgb)
      draw = 1'b0;
    last_px = 1'b0;
    if ({21'd0, col_idx} + 32'd1 >= img_w) begin
      col_idx = '0;
      if ({21'd0, row_idx} + 32'd1 >= img_h) begin
        last_px = 1'b1;
        phase_q = IMAGE_DONE;
      end else begin
        row_idx++;
        if (pad_len != 0)
          phase_q = SKIP_PAD;
      end
    end else begin
      col_idx++;
    end
    r.kind = KIND_PIXEL;
    r.pixel_x = px[15:0];
    r.pixel_y = py[15:0];
    r.color = rgb;
    r.write_enable = draw;
    r.last = last_px;
    return 1'b1;
  endfunction

  function automatic logic decode_byte(input logic [7:0] b, input logic first,
                                       output result_t r);
    logic [31:0] idx;
    r = '0;
    if (first)
      restart_decoder();
    idx = hdr_pos;
    if (hdr_pos != 32'hFFFF_FFFF)
      hdr_pos++;
    case (phase_q)
      PARSE_HDR: begin
        hdr_shift = {b, hdr_shift[31:8]};
        case (idx)
          POS_SIG: begin
            if (hdr_shift[31:16] != BMP_SIGNATURE) begin
              err_bits = E_SIG;
              img_ok = 1'b0;
              phase_q = IMAGE_DONE;
              r.kind = KIND_VERDICT;
              r.status = err_bits;
              r.last = 1'b1;
              return 1'b1;
            end
          end
          POS_OFFSET: pix_offset = hdr_shift;
          POS_HLEN:   hdr_len = hdr_shift;
          POS_WIDTH:  img_w = hdr_shift;
          POS_HEIGHT: img_h = hdr_shift;
          POS_PLANES: begin
            if (hdr_shift[31:16] != BMP_PLANES_1)
              err_bits |= E_PLANES;
          end
          POS_DEPTH: begin
            if (hdr_shift[31:16] != BMP_DEPTH_24)
              err_bits |= E_DEPTH;
            if (hdr_len <= BMP_SHORT_HDR) begin
              close_header(r);
              return 1'b1;
            end
          end
          POS_COMPR: begin
            if (hdr_shift != 0)
              err_bits |= E_COMPR;
            close_header(r);
            return 1'b1;
          end
          default: ;
        endcase
        return 1'b0;
      end
      SEEK_DATA: begin
        if (idx < pix_offset)
          return 1'b0;
        phase_q = TAKE_PIXEL;
        return take_pixel(b, r);
      end
      TAKE_PIXEL: return take_pixel(b, r);
      SKIP_PAD: begin
        bgr_idx++;
        if (bgr_idx >= pad_len) begin
          bgr_idx = '0;
          phase_q = TAKE_PIXEL;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++)
      file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void build_file(input bmp_file_t d);
    logic [7:0] key_px [3];
    int         pad;
    file_bytes.delete();
    put_le(d.sig, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(d.offset, 4);
    put_le(d.hlen, 4);
    put_le(d.width, 4);
    put_le(d.height, 4);
    put_le(d.planes, 2);
    put_le(d.depth, 2);
    put_le(d.compr, 4);
    if (d.offset > 34 && d.offset < 128)
      repeat (d.offset - 34) put_le($urandom, 1);
    foreach (key_px[c])
      key_px[c] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    if (d.width <= MAX_DIM && d.height <= MAX_DIM && d.width * d.height <= 4096) begin
      pad = (4 - (d.width * 3) % 4) % 4;
      for (int y = 0; y < d.height; y++) begin
        for (int x = 0; x < d.width; x++) begin
          // repeat the first pixel often so keying gets hit
          if ((x == 0 && y == 0) || $urandom_range(99) < 35)
            foreach (key_px[c]) file_bytes.push_back(key_px[c]);
          else
            put_le($urandom, 3);
        end
        repeat (pad) put_le($urandom, 1);
      end
    end else begin
      put_le($urandom, 3);
      put_le($urandom, 3);
    end
    repeat ($urandom_range(3)) put_le($urandom, 1);
    if (d.cut > 0)
      while (file_bytes.size() > d.cut) void'(file_bytes.pop_back());
  endfunction

  function automatic bmp_file_t random_file();
    bmp_file_t d;
    int        pick;
    d = '{BMP_SIGNATURE, 54, 40, $urandom_range(1, 5), $urandom_range(1, 3), BMP_PLANES_1,
          BMP_DEPTH_24, 0, 1, 0, 0, E_NONE, 0};
    case ($urandom_range(3))
      0: ;
      1: begin d.hlen = 12; d.offset = 34; end
      2: begin d.hlen = $urandom_range(64); d.offset = $urandom_range(34, 70); end
      default: d.offset = $urandom_range(33);
    endcase
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(5))
        0: d.sig = 16'($urandom);
        1: d.planes = 16'($urandom_range(3));
        2: d.depth = 16'($urandom);
        3: d.compr = $urandom;
        4: d.width = $urandom;
        default: d.height = $urandom | 32'h800;
      endcase
    end else if (pick < 15) begin
      d.offset = $urandom; d.hlen = $urandom; d.width = $urandom; d.height = $urandom;
      d.planes = 16'($urandom); d.depth = 16'($urandom); d.compr = $urandom;
    end else if (pick < 22) begin
      d.cut = $urandom_range(2, 50);
    end else if (pick < 26) begin
      if ($urandom_range(1)) d.width = 0;
      else d.height = 0;
    end
    d.mark_first = ($urandom_range(19) != 0);
    return d;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file(input bmp_file_t d);
    typed_on = d.typed;
    typed_status = d.t_status;
    typed_last = d.t_last;
    build_file(d);
    foreach (file_bytes[i])
      push_byte(file_bytes[i], (i == 0) ? d.mark_first : 1'b0);
  endtask

  task automatic send_noise();
    typed_on = 1'b0;
    repeat ($urandom_range(3, 12)) push_byte(8'($urandom), $urandom_range(3) == 0);
  endtask

  task automatic cfg_reg(input logic [CFG_A_W-1:0] a, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                input logic ft);
    // drain, then let trailing bytes clear the pipe
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_reg(REG_SCREEN_WIDTH, CFG_W'(sw));
    cfg_reg(REG_SCREEN_HEIGHT, CFG_W'(sh));
    cfg_reg(REG_CENTER_X, cx);
    cfg_reg(REG_CENTER_Y, cy);
    cfg_reg(REG_FORCE_TRANSP, CFG_W'(ft));
    cfg_we <= 1'b0;
    m_cfg.screen_width = sw;
    m_cfg.screen_height = sh;
    m_cfg.center_x = cx;
    m_cfg.center_y = cy;
    m_cfg.force_transparent = ft;
  endtask

  task automatic setting_for(input int n);
    logic [DIM_W-1:0] sw, sh;
    case (n)
      0: write_settings(11'd1024, 11'd1024, 16'd1023, 16'd1023, 1'b0);
      1: write_settings(11'd1, 11'd1, 16'd0, 16'd0, 1'b1);
      2: write_settings(11'd480, 11'd320, 16'h8000, 16'h8000, 1'b0);
      3: write_settings(11'd480, 11'd320, 16'h7FFF, 16'd0, 1'b1);
      4: write_settings(11'd1024, 11'd1024, 16'd0, 16'd1024, 1'b0);
      default: begin
        sw = DIM_W'($urandom_range(1, 1024));
        sh = DIM_W'($urandom_range(1, 1024));
        write_settings(sw, sh, 16'(int'($urandom_range(0, int'(sw) + 16)) - 8),
                       16'(int'($urandom_range(0, int'(sh) + 16)) - 8), $urandom_range(1));
      end
    endcase
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin : track_in
    result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser || phase_q != IMAGE_DONE)
        live_bytes++;
      if (decode_byte(in_tdata, in_tuser, r)) begin
        if (typed_on && r.kind == KIND_VERDICT) begin
          r.status = typed_status;
          r.last = typed_last;
        end
        pending_results.push_back(r);
      end
    end
  end

  always @(posedge clk) begin : check_out
    result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[5:0], out_tdata[21:6], out_tdata[37:22],
             out_tdata[53:38], out_tdata[54], out_tlast};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected word: kind %0d status %h x %h y %h color %h we %0d last %0d",
                   $time, got.kind, got.status, got.pixel_x, got.pixel_y, got.color,
                   got.write_enable, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.color !== want.color || got.write_enable !== want.write_enable ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch (kind/status/x/y/color/we/last) expected ",
                      "%0d/%h/%h/%h/%h/%0d/%0d actual %0d/%h/%h/%h/%h/%0d/%0d"},
                     $time, want.kind, want.status, want.pixel_x, want.pixel_y,
                     want.color, want.write_enable, want.last, got.kind, got.status,
                     got.pixel_x, got.pixel_y, got.color, got.write_enable, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run
    int base, n;
    m_cfg = '{SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 16'sd0, 16'sd0, 1'b0};
    restart_decoder();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_files[i])
      send_file(dir_files[i]);

    base = live_bytes;
    n = 0;
    while (n < 6 || live_bytes - base < RANDOM_BYTES) begin
      // hold both sides busy for a stretch
      idle_pct = (n == 5 || n == 6) ? 0 : 29;
      setting_for(n);
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(5) == 0)
          send_noise();
        send_file(random_file());
      end
      n++;
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/b24r_pkg.sv
src/b24r_core.sv
src/b24r_obuf.sv
src/bmp24_stream_to_rgb565_top.sv
dv/bmp24_stream_to_rgb565_top_test.sv
